@@ rtl/core/sol_pkg.sv @@
// Shared types and constants for the stacking order list.
package sol_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int LINK_W  = $clog2(ENTRIES + 1);
  localparam int MODE_W  = 3;
  localparam int ENTRY_W = 6;

  localparam logic [LINK_W-1:0] NONE_CODE = LINK_W'(ENTRIES);

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 3'd0,
    MODE_RAISE  = 3'd1,
    MODE_LOWER  = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_QUERY  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DETACH,
    ST_ATTACH,
    ST_SEAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [LINK_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

  typedef struct packed {
    logic [LINK_W-1:0] top_entry;
    logic [LINK_W-1:0] bottom_entry;
    logic [LINK_W-1:0] entry_above;
    logic [LINK_W-1:0] entry_below;
    logic              in_stack;
    logic              error;
  } res_t;

endpackage

@@ rtl/core/sol_if.sv @@
// Valid/ready channel interfaces for operation words and result words.
interface sol_in_if import sol_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [ENTRY_W-1:0] entry;

  modport source (output valid, output mode, output entry, input ready);
  modport sink (input valid, input mode, input entry, output ready);
endinterface

interface sol_out_if import sol_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LINK_W-1:0] top_entry;
  logic [LINK_W-1:0] bottom_entry;
  logic [LINK_W-1:0] entry_above;
  logic [LINK_W-1:0] entry_below;
  logic              in_stack;
  logic              error;

  modport source (output valid, output top_entry, output bottom_entry, output entry_above,
                  output entry_below, output in_stack, output error, input ready);
  modport sink (input valid, input top_entry, input bottom_entry, input entry_above,
                input entry_below, input in_stack, input error, output ready);
endinterface

@@ rtl/core/sol_link_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sol_link_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 7
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/sol_ctrl.sv @@
// Operation sequencer: pointers, membership flags and link memory updates.
module sol_ctrl import sol_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [ENTRY_W-1:0] in_entry,
  output ram_req_t           above_req,
  output ram_req_t           below_req,
  input  logic [LINK_W-1:0]  above_q,
  input  logic [LINK_W-1:0]  below_q,
  output logic               res_valid,
  input  logic               res_ready,
  output res_t               res
);

  state_t              state_r, state_nxt;
  logic [MODE_W-1:0]   mode_r;
  logic [IDX_W-1:0]    ent_r;
  logic                ok_r;
  logic [LINK_W-1:0]   up_r, up_nxt;
  logic [LINK_W-1:0]   down_r, down_nxt;
  logic [LINK_W-1:0]   top_r, top_nxt;
  logic [LINK_W-1:0]   bot_r, bot_nxt;
  logic [LINK_W-1:0]   ea_r, ea_nxt;
  logic [LINK_W-1:0]   eb_r, eb_nxt;
  logic                err_r, err_nxt;
  logic                det_r, det_nxt;
  logic                att_top_r, att_top_nxt;
  logic                att_bot_r, att_bot_nxt;
  logic [ENTRIES-1:0]  flags_r, flags_nxt;
  logic                present;
  logic [LINK_W-1:0]   ent_link;
  logic                accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign ent_link = LINK_W'(ent_r);
  assign present  = ok_r && flags_r[ent_r];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        if (det_nxt) state_nxt = ST_DETACH;
        else if (att_top_nxt || att_bot_nxt) state_nxt = ST_ATTACH;
        else state_nxt = ST_DONE;
      end
      ST_DETACH: begin
        if (att_top_r || att_bot_r) state_nxt = ST_ATTACH;
        else state_nxt = ST_DONE;
      end
      ST_ATTACH: state_nxt = ST_SEAL;
      ST_SEAL:   state_nxt = ST_DONE;
      ST_DONE: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    above_req       = '0;
    below_req       = '0;
    above_req.raddr = IDX_W'(in_entry);
    below_req.raddr = IDX_W'(in_entry);
    up_nxt          = up_r;
    down_nxt        = down_r;
    top_nxt         = top_r;
    bot_nxt         = bot_r;
    ea_nxt          = ea_r;
    eb_nxt          = eb_r;
    err_nxt         = err_r;
    det_nxt         = det_r;
    att_top_nxt     = att_top_r;
    att_bot_nxt     = att_bot_r;
    flags_nxt       = flags_r;
    unique case (state_r)
      ST_LOOK: begin
        up_nxt      = above_q;
        down_nxt    = below_q;
        err_nxt     = 1'b0;
        det_nxt     = 1'b0;
        att_top_nxt = 1'b0;
        att_bot_nxt = 1'b0;
        ea_nxt      = present ? above_q : NONE_CODE;
        eb_nxt      = present ? below_q : NONE_CODE;
        unique case (mode_r)
          MODE_APPEND: begin
            if (!ok_r || present) begin
              err_nxt = 1'b1;
            end else begin
              att_bot_nxt       = 1'b1;
              flags_nxt[ent_r]  = 1'b1;
            end
          end
          MODE_RAISE: begin
            if (!present) begin
              err_nxt = 1'b1;
            end else if (top_r != ent_link) begin
              det_nxt     = 1'b1;
              att_top_nxt = 1'b1;
            end
          end
          MODE_LOWER: begin
            if (!present) begin
              err_nxt = 1'b1;
            end else if (bot_r != ent_link) begin
              det_nxt     = 1'b1;
              att_bot_nxt = 1'b1;
            end
          end
          MODE_REMOVE: begin
            if (!present) begin
              err_nxt = 1'b1;
            end else begin
              det_nxt          = 1'b1;
              flags_nxt[ent_r] = 1'b0;
              ea_nxt           = NONE_CODE;
              eb_nxt           = NONE_CODE;
            end
          end
          MODE_QUERY: ;
          default: err_nxt = 1'b1;
        endcase
      end
      ST_DETACH: begin
        if (up_r < NONE_CODE) begin
          below_req.we    = 1'b1;
          below_req.waddr = IDX_W'(up_r);
          below_req.wdata = down_r;
        end else begin
          top_nxt = down_r;
        end
        if (down_r < NONE_CODE) begin
          above_req.we    = 1'b1;
          above_req.waddr = IDX_W'(down_r);
          above_req.wdata = up_r;
        end else begin
          bot_nxt = up_r;
        end
      end
      ST_ATTACH: begin
        if (att_top_r) begin
          below_req.we    = 1'b1;
          below_req.waddr = ent_r;
          below_req.wdata = top_r;
          if (top_r < NONE_CODE) begin
            above_req.we    = 1'b1;
            above_req.waddr = IDX_W'(top_r);
            above_req.wdata = ent_link;
          end else begin
            bot_nxt = ent_link;
          end
          top_nxt = ent_link;
          ea_nxt  = NONE_CODE;
          eb_nxt  = top_r;
        end else begin
          above_req.we    = 1'b1;
          above_req.waddr = ent_r;
          above_req.wdata = bot_r;
          if (bot_r < NONE_CODE) begin
            below_req.we    = 1'b1;
            below_req.waddr = IDX_W'(bot_r);
            below_req.wdata = ent_link;
          end else begin
            top_nxt = ent_link;
          end
          bot_nxt = ent_link;
          ea_nxt  = bot_r;
          eb_nxt  = NONE_CODE;
        end
      end
      ST_SEAL: begin
        if (att_top_r) begin
          above_req.we    = 1'b1;
          above_req.waddr = ent_r;
          above_req.wdata = NONE_CODE;
        end else begin
          below_req.we    = 1'b1;
          below_req.waddr = ent_r;
          below_req.wdata = NONE_CODE;
        end
      end
      default: ;
    endcase
  end

  assign res_valid        = (state_r == ST_DONE);
  assign res.top_entry    = top_r;
  assign res.bottom_entry = bot_r;
  assign res.entry_above  = ea_r;
  assign res.entry_below  = eb_r;
  assign res.in_stack     = present;
  assign res.error        = err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      top_r     <= NONE_CODE;
      bot_r     <= NONE_CODE;
      flags_r   <= '0;
      det_r     <= 1'b0;
      att_top_r <= 1'b0;
      att_bot_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      top_r     <= top_nxt;
      bot_r     <= bot_nxt;
      flags_r   <= flags_nxt;
      det_r     <= det_nxt;
      att_top_r <= att_top_nxt;
      att_bot_r <= att_bot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      ent_r  <= IDX_W'(in_entry);
      ok_r   <= (32'(in_entry) < 32'(ENTRIES));
    end
    up_r   <= up_nxt;
    down_r <= down_nxt;
    ea_r   <= ea_nxt;
    eb_r   <= eb_nxt;
    err_r  <= err_nxt;
  end

endmodule

@@ rtl/core/stacking_order_list.sv @@
// Steps: LOOK, DETACH for raise, lower or remove, ATTACH and SEAL for append, raise or lower,
// then DONE, where it waits through an output stall, and the output register. One word at a
// time, accepted only in IDLE. The single write port of each link RAM splits the steps.
// Reset: top and bottom pointers empty, membership flags cleared, links left undefined;
// no clearing pass, words accepted right after reset.
module stacking_order_list import sol_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  sol_in_if.sink        in_word,
  sol_out_if.source     out_word
);

  ram_req_t          above_req, below_req;
  logic [LINK_W-1:0] above_q, below_q;
  logic              res_valid, res_ready;
  res_t              res;
  res_t              res_r;
  logic              out_valid_r;

  sol_link_ram #(.DEPTH(ENTRIES), .WIDTH(LINK_W)) u_above_ram (
    .clk   (clk),
    .we    (above_req.we),
    .waddr (above_req.waddr),
    .wdata (above_req.wdata),
    .raddr (above_req.raddr),
    .rdata (above_q)
  );

  sol_link_ram #(.DEPTH(ENTRIES), .WIDTH(LINK_W)) u_below_ram (
    .clk   (clk),
    .we    (below_req.we),
    .waddr (below_req.waddr),
    .wdata (below_req.wdata),
    .raddr (below_req.raddr),
    .rdata (below_q)
  );

  sol_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_word.valid),
    .in_ready  (in_word.ready),
    .in_mode   (in_word.mode),
    .in_entry  (in_word.entry),
    .above_req (above_req),
    .below_req (below_req),
    .above_q   (above_q),
    .below_q   (below_q),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_word.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

  assign out_word.valid        = out_valid_r;
  assign out_word.top_entry    = res_r.top_entry;
  assign out_word.bottom_entry = res_r.bottom_entry;
  assign out_word.entry_above  = res_r.entry_above;
  assign out_word.entry_below  = res_r.entry_below;
  assign out_word.in_stack     = res_r.in_stack;
  assign out_word.error        = res_r.error;

endmodule
